/* hw/rtl/udp_port_packet_filter_unit_macros.svh */
// Assertion macros shared by the UDP port filter RTL.
`ifndef UDP_PORT_PACKET_FILTER_UNIT_MACROS_SVH
`define UDP_PORT_PACKET_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UDPF_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UDPF_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/udpf_pkg.sv */
// Package with the word types and protocol constants of the UDP port filter.
`timescale 1ns / 1ps

package udpf_pkg;

    localparam int LEN_W = 16;

    localparam logic [15:0] ETH_HDR_BYTES  = 16'd14;
    localparam logic [15:0] IP_MIN_BYTES   = 16'd20;
    localparam logic [15:0] UDP_HDR_BYTES  = 16'd8;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [3:0]  IP_VERSION_4   = 4'd4;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    localparam logic [15:0] OFF_DMAC_END   = 16'd6;
    localparam logic [15:0] OFF_SMAC_END   = 16'd12;
    localparam logic [15:0] OFF_ETYPE_END  = 16'd14;
    localparam logic [15:0] OFF_VER_IHL    = 16'd14;
    localparam logic [15:0] OFF_TLEN_HI    = 16'd16;
    localparam logic [15:0] OFF_TLEN_LO    = 16'd17;
    localparam logic [15:0] OFF_PROTO      = 16'd23;
    localparam logic [15:0] OFF_SIP        = 16'd26;
    localparam logic [15:0] OFF_DIP        = 16'd30;
    localparam logic [15:0] OFF_IP_END     = 16'd34;
    localparam logic [3:0]  IHL_MIN        = 4'd5;

    localparam logic [3:0] REASON_OK        = 4'd0;
    localparam logic [3:0] REASON_SHORT_ETH = 4'd1;
    localparam logic [3:0] REASON_NOT_IPV4  = 4'd2;
    localparam logic [3:0] REASON_SHORT_IP  = 4'd3;
    localparam logic [3:0] REASON_VERSION   = 4'd4;
    localparam logic [3:0] REASON_NOT_UDP   = 4'd5;
    localparam logic [3:0] REASON_IHL       = 4'd6;
    localparam logic [3:0] REASON_SHORT_UDP = 4'd7;
    localparam logic [3:0] REASON_PORT      = 4'd8;

    localparam logic [1:0] CFG_FILTER_MODE = 2'd0;
    localparam logic [1:0] CFG_CHAT_PORT   = 2'd1;
    localparam logic [1:0] CFG_DNS_PORT    = 2'd2;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
    } in_word_t;

    typedef struct packed {
        logic        accept;
        logic [3:0]  drop_reason;
        logic [11:0] frame_length;
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [31:0] src_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_udp_port;
        logic [15:0] dest_udp_port;
        logic [15:0] payload_bytes;
    } out_word_t;

    typedef struct packed {
        logic [LEN_W-1:0] frame_len;
        logic [47:0]      dest_mac;
        logic [47:0]      source_mac;
        logic [15:0]      ethertype;
        logic [7:0]       version_ihl;
        logic [15:0]      total_length;
        logic [7:0]       protocol;
        logic [31:0]      src_ip;
        logic [31:0]      dest_ip;
        logic [15:0]      src_port;
        logic [15:0]      dest_port;
    } hdr_rec_t;

endpackage

/* hw/rtl/udpf_parser.sv */
// Front end: counts frame bytes and captures the header fields of each frame.
`timescale 1ns / 1ps

module udpf_parser #(
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  udpf_pkg::in_word_t in_data,
    output logic               rec_valid,
    input  logic               rec_ready,
    output udpf_pkg::hdr_rec_t rec_data
);

    localparam int OFF_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [OFF_W-1:0] MAX_OFF = OFF_W'(MAX_FRAME_BYTES);

    logic [OFF_W-1:0] offset_reg, offset_next;
    logic [47:0] dmac_reg, dmac_next;
    logic [47:0] smac_reg, smac_next;
    logic [15:0] etype_reg, etype_next;
    logic [7:0]  ver_ihl_reg, ver_ihl_next;
    logic [15:0] tlen_reg, tlen_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] sip_reg, sip_next;
    logic [31:0] dip_reg, dip_next;
    logic [15:0] sport_reg, sport_next;
    logic [15:0] dport_reg, dport_next;

    logic        take;
    logic [15:0] off16;
    logic [15:0] port_base;
    logic [7:0]  b;

    assign in_ready  = rec_ready;
    assign take      = in_valid && in_ready;
    assign rec_valid = take && in_data.frame_last;
    assign b         = in_data.frame_byte;
    assign off16     = 16'(offset_reg);
    assign port_base = udpf_pkg::ETH_HDR_BYTES + 16'({ver_ihl_reg[3:0], 2'b00});

    always_comb
    begin
        offset_next  = offset_reg;
        dmac_next    = dmac_reg;
        smac_next    = smac_reg;
        etype_next   = etype_reg;
        ver_ihl_next = ver_ihl_reg;
        tlen_next    = tlen_reg;
        proto_next   = proto_reg;
        sip_next     = sip_reg;
        dip_next     = dip_reg;
        sport_next   = sport_reg;
        dport_next   = dport_reg;
        if (take && (offset_reg < MAX_OFF))
        begin
            offset_next = offset_reg + OFF_W'(1);
            if (off16 < udpf_pkg::OFF_DMAC_END)
            begin
                dmac_next = {dmac_reg[39:0], b};
            end
            else if (off16 < udpf_pkg::OFF_SMAC_END)
            begin
                smac_next = {smac_reg[39:0], b};
            end
            else if (off16 < udpf_pkg::OFF_ETYPE_END)
            begin
                etype_next = {etype_reg[7:0], b};
            end
            else if (off16 == udpf_pkg::OFF_VER_IHL)
            begin
                ver_ihl_next = b;
            end
            else if ((off16 == udpf_pkg::OFF_TLEN_HI) || (off16 == udpf_pkg::OFF_TLEN_LO))
            begin
                tlen_next = {tlen_reg[7:0], b};
            end
            else if (off16 == udpf_pkg::OFF_PROTO)
            begin
                proto_next = b;
            end
            else if ((off16 >= udpf_pkg::OFF_SIP) && (off16 < udpf_pkg::OFF_DIP))
            begin
                sip_next = {sip_reg[23:0], b};
            end
            else if ((off16 >= udpf_pkg::OFF_DIP) && (off16 < udpf_pkg::OFF_IP_END))
            begin
                dip_next = {dip_reg[23:0], b};
            end

            // The UDP header sits right after the IP header, whose size is in IHL.
            if (ver_ihl_reg[3:0] >= udpf_pkg::IHL_MIN)
            begin
                if ((off16 == port_base) || (off16 == port_base + 16'd1))
                begin
                    sport_next = {sport_reg[7:0], b};
                end
                else if ((off16 == port_base + 16'd2) || (off16 == port_base + 16'd3))
                begin
                    dport_next = {dport_reg[7:0], b};
                end
            end
        end
    end

    always_comb
    begin
        rec_data.frame_len    = udpf_pkg::LEN_W'(offset_next);
        rec_data.dest_mac     = dmac_next;
        rec_data.source_mac   = smac_next;
        rec_data.ethertype    = etype_next;
        rec_data.version_ihl  = ver_ihl_next;
        rec_data.total_length = tlen_next;
        rec_data.protocol     = proto_next;
        rec_data.src_ip       = sip_next;
        rec_data.dest_ip      = dip_next;
        rec_data.src_port     = sport_next;
        rec_data.dest_port    = dport_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= '0;
            dmac_reg    <= '0;
            smac_reg    <= '0;
            etype_reg   <= '0;
            ver_ihl_reg <= '0;
            tlen_reg    <= '0;
            proto_reg   <= '0;
            sip_reg     <= '0;
            dip_reg     <= '0;
            sport_reg   <= '0;
            dport_reg   <= '0;
        end
        else if (rec_valid)
        begin
            // The last word of a frame hands its fields on and starts the next frame clean.
            offset_reg  <= '0;
            dmac_reg    <= '0;
            smac_reg    <= '0;
            etype_reg   <= '0;
            ver_ihl_reg <= '0;
            tlen_reg    <= '0;
            proto_reg   <= '0;
            sip_reg     <= '0;
            dip_reg     <= '0;
            sport_reg   <= '0;
            dport_reg   <= '0;
        end
        else
        begin
            offset_reg  <= offset_next;
            dmac_reg    <= dmac_next;
            smac_reg    <= smac_next;
            etype_reg   <= etype_next;
            ver_ihl_reg <= ver_ihl_next;
            tlen_reg    <= tlen_next;
            proto_reg   <= proto_next;
            sip_reg     <= sip_next;
            dip_reg     <= dip_next;
            sport_reg   <= sport_next;
            dport_reg   <= dport_next;
        end
    end

endmodule

/* hw/rtl/udpf_queue.sv */
// Two-entry queue of captured header records between the parser and the verdict stage.
`timescale 1ns / 1ps
`include "udp_port_packet_filter_unit_macros.svh"

module udpf_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  udpf_pkg::hdr_rec_t push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output udpf_pkg::hdr_rec_t pop_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    udpf_pkg::hdr_rec_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `UDPF_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= FULL_CNT, "queue count overflow")
    `UDPF_ASSERT_NEXT(a_push_only_grows, clk, rst_n, push && !pop, count_reg == $past(count_reg) + CNT_W'(1), "queue count did not follow a push")

endmodule

/* hw/rtl/udpf_verdict.sv */
// Back end: checks one header record, forms the verdict and holds it in the output register.
`timescale 1ns / 1ps
`include "udp_port_packet_filter_unit_macros.svh"

module udpf_verdict (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rec_valid,
    output logic                rec_ready,
    input  udpf_pkg::hdr_rec_t  rec_data,
    input  logic [15:0]         match_port,
    output logic                out_valid,
    input  logic                out_ready,
    output udpf_pkg::out_word_t out_data
);

    logic                out_valid_reg, out_valid_next;
    udpf_pkg::out_word_t out_data_reg, out_data_next;

    logic [15:0] hdr_bytes;
    logic [15:0] udp_need;
    logic [15:0] ip_udp_bytes;
    logic [15:0] payload;
    logic [3:0]  reason;
    logic        load;

    assign rec_ready = !out_valid_reg || out_ready;
    assign load      = rec_valid && rec_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign hdr_bytes    = 16'({rec_data.version_ihl[3:0], 2'b00});
    assign udp_need     = udpf_pkg::ETH_HDR_BYTES + hdr_bytes + udpf_pkg::UDP_HDR_BYTES;
    assign ip_udp_bytes = hdr_bytes + udpf_pkg::UDP_HDR_BYTES;
    assign payload      = (rec_data.total_length > ip_udp_bytes)
                        ? rec_data.total_length - ip_udp_bytes : 16'd0;

    always_comb
    begin
        if (rec_data.frame_len < udpf_pkg::ETH_HDR_BYTES)
        begin
            reason = udpf_pkg::REASON_SHORT_ETH;
        end
        else if (rec_data.ethertype != udpf_pkg::ETHERTYPE_IPV4)
        begin
            reason = udpf_pkg::REASON_NOT_IPV4;
        end
        else if (rec_data.frame_len < udpf_pkg::OFF_IP_END)
        begin
            reason = udpf_pkg::REASON_SHORT_IP;
        end
        else if (rec_data.version_ihl[7:4] != udpf_pkg::IP_VERSION_4)
        begin
            reason = udpf_pkg::REASON_VERSION;
        end
        else if (rec_data.protocol != udpf_pkg::PROTO_UDP)
        begin
            reason = udpf_pkg::REASON_NOT_UDP;
        end
        else if (hdr_bytes < udpf_pkg::IP_MIN_BYTES)
        begin
            reason = udpf_pkg::REASON_IHL;
        end
        else if (rec_data.frame_len < udp_need)
        begin
            reason = udpf_pkg::REASON_SHORT_UDP;
        end
        else if ((rec_data.src_port != match_port) && (rec_data.dest_port != match_port))
        begin
            reason = udpf_pkg::REASON_PORT;
        end
        else
        begin
            reason = udpf_pkg::REASON_OK;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (load)
        begin
            out_valid_next             = 1'b1;
            out_data_next              = '0;
            out_data_next.accept       = (reason == udpf_pkg::REASON_OK);
            out_data_next.drop_reason  = reason;
            out_data_next.frame_length = rec_data.frame_len[11:0];
            // A dropped frame reports only its reason and length.
            if (reason == udpf_pkg::REASON_OK)
            begin
                out_data_next.dest_mac        = rec_data.dest_mac;
                out_data_next.source_mac      = rec_data.source_mac;
                out_data_next.src_ip          = rec_data.src_ip;
                out_data_next.dest_ip         = rec_data.dest_ip;
                out_data_next.source_udp_port = rec_data.src_port;
                out_data_next.dest_udp_port   = rec_data.dest_port;
                out_data_next.payload_bytes   = payload;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    `UDPF_ASSERT_NOW(a_accept_reason, clk, rst_n, out_valid_reg, out_data_reg.accept == (out_data_reg.drop_reason == udpf_pkg::REASON_OK), "accept flag disagrees with reason")
    `UDPF_ASSERT_NOW(a_drop_clears, clk, rst_n, out_valid_reg && !out_data_reg.accept, (out_data_reg.dest_mac == '0) && (out_data_reg.payload_bytes == '0), "dropped frame carries header fields")
    `UDPF_ASSERT_NEXT(a_load_shows, clk, rst_n, load, out_valid_reg, "loaded verdict not presented")

endmodule

/* hw/rtl/udp_port_packet_filter_unit.sv */
// Top level of the UDP port filter: configuration registers, parser, record queue and verdict stage.
`timescale 1ns / 1ps

// Frame words enter one per cycle unless the input is stalled, and the parser captures the
// header fields as the bytes pass, with no gap needed between frames. The last word of a
// frame hands a header record to a two-entry queue, and the verdict stage turns one record
// per cycle, unless its output is stalled, into a result word in its output register. The
// input stalls only when the queue is full, that is, when two header records wait behind a
// verdict held by a stalled output. Configuration is written through its own channel, which
// is always ready, and takes effect on the next verdict.
module udp_port_packet_filter_unit #(
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  udpf_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output udpf_pkg::out_word_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    logic        filter_mode_reg, filter_mode_next;
    logic [15:0] chat_port_reg, chat_port_next;
    logic [15:0] dns_port_reg, dns_port_next;
    logic [15:0] match_port;

    logic               pq_valid;
    logic               pq_ready;
    udpf_pkg::hdr_rec_t pq_data;
    logic               qv_valid;
    logic               qv_ready;
    udpf_pkg::hdr_rec_t qv_data;

    assign cfg_ready  = 1'b1;
    assign match_port = filter_mode_reg ? dns_port_reg : chat_port_reg;

    always_comb
    begin
        filter_mode_next = filter_mode_reg;
        chat_port_next   = chat_port_reg;
        dns_port_next    = dns_port_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                udpf_pkg::CFG_FILTER_MODE: filter_mode_next = cfg_data[0];
                udpf_pkg::CFG_CHAT_PORT:   chat_port_next   = cfg_data;
                udpf_pkg::CFG_DNS_PORT:    dns_port_next    = cfg_data;
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mode_reg <= 1'b1;
            chat_port_reg   <= 16'd0;
            dns_port_reg    <= 16'd53;
        end
        else
        begin
            filter_mode_reg <= filter_mode_next;
            chat_port_reg   <= chat_port_next;
            dns_port_reg    <= dns_port_next;
        end
    end

    udpf_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .rec_valid (pq_valid),
        .rec_ready (pq_ready),
        .rec_data  (pq_data)
    );

    udpf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (pq_valid),
        .push_ready (pq_ready),
        .push_data  (pq_data),
        .pop_valid  (qv_valid),
        .pop_ready  (qv_ready),
        .pop_data   (qv_data)
    );

    udpf_verdict u_verdict (
        .clk        (clk),
        .rst_n      (rst_n),
        .rec_valid  (qv_valid),
        .rec_ready  (qv_ready),
        .rec_data   (qv_data),
        .match_port (match_port),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule
